/* sv/multi_channel_pwm_controller_top_assert.svh */
// Assertion macros for the PWM controller
`ifndef MULTI_CHANNEL_PWM_CONTROLLER_TOP_ASSERT_SVH
`define MULTI_CHANNEL_PWM_CONTROLLER_TOP_ASSERT_SVH
`define PWM_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pwm: %s failed", "label");
`define PWM_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pwm: %s failed", "label");
`endif

/* sv/mcpwm_pkg.sv */
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared constants and codes for the PWM controller.
// ----------------------------------------------------------------------------
`default_nettype none
package mcpwm_pkg;
  localparam int CHANNELS_DEF = 16;
  localparam int TIMERS_DEF   = 8;
  localparam int RES_DEF      = 20;
  localparam int WORD_W       = 32;
  localparam int IRQ_TMR_BASE = 16;
  localparam logic [4:0] RES_FIELD_MASK = 5'h1F;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [3:0] SEL_TCONF  = 4'd0;
  localparam logic [3:0] SEL_TVALUE = 4'd1;
  localparam logic [3:0] SEL_CONF0  = 4'd2;
  localparam logic [3:0] SEL_HPOINT = 4'd3;
  localparam logic [3:0] SEL_DUTY   = 4'd4;
  localparam logic [3:0] SEL_CONF1  = 4'd5;
  localparam logic [3:0] SEL_DUTY_R = 4'd6;
  localparam logic [3:0] SEL_IRAW   = 4'd7;
  localparam logic [3:0] SEL_IST    = 4'd8;
  localparam logic [3:0] SEL_IENA   = 4'd9;
  localparam logic [3:0] SEL_ICLR   = 4'd10;

  localparam int EN_POS    = 2;
  localparam int IDLE_POS  = 1;
  localparam int START_POS = 4;
  localparam int TSEL_LO   = 8;
  localparam int DUTY_LO   = 4;

  typedef struct packed {
    logic [19:0] cnt;
    logic [4:0]  res;
    logic [31:0] hpoint;
    logic [31:0] duty;
    logic        en;
    logic        idle;
  } lvl_req_t;
endpackage
`default_nettype wire

/* sv/mcpwm_level.sv */
// ----------------------------------------------------------------------------
// mcpwm_level
// Shared level unit: computes one channel level per request, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module mcpwm_level #(
  parameter int MAX_RES_BITS = mcpwm_pkg::RES_DEF
) (
  input  wire                 clk,
  input  mcpwm_pkg::lvl_req_t req,
  output logic                level
);
  localparam int RW = MAX_RES_BITS;
  logic [RW:0]   period;
  logic [RW-1:0] pmask;
  logic [RW-1:0] duty;
  logic [RW-1:0] rel;
  logic          lv;

  always_comb begin
    period = (RW+1)'(1) << req.res;
    pmask  = RW'(period - (RW+1)'(1));
    duty   = req.duty[mcpwm_pkg::DUTY_LO +: RW];
    if ({1'b0, duty} >= period) duty = pmask;
    rel = (RW'(req.cnt) - req.hpoint[RW-1:0]) & pmask;
    lv  = req.en ? (rel < duty) : req.idle;
  end

  always_ff @(posedge clk) begin
    level <= lv;
  end
endmodule
`default_nettype wire

/* sv/multi_channel_pwm_controller_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_pwm_controller_top
// PWM controller with timers and channels behind a register command port.
// ----------------------------------------------------------------------------
// Input channel: valid/stall with command, unit_index, reg_select, write_data.
// One transaction is a register read, a register write or one timer tick.
// Output channel: valid/stall with read_data, irq and channel_levels; one
// result per input transaction.
// For reads and for writes that need no level refresh the result is set in
// S_DONE straight after S_EXEC; a write that refreshes one channel (conf0,
// duty, duty_r, conf1 with start) passes S_CALC and S_WAIT first. A tick on a
// valid timer walks every channel through the single shared level unit, one
// channel per cycle in S_SCAN, and then passes S_WAIT before S_DONE.
// The block takes one transaction at a time; stall is high from acceptance
// until the result has been taken, and the next transaction can be accepted
// on the cycle after that.
// A receiver stall holds the result in the output register and the block
// waits. Synchronous reset clears all registers but the captured command
// fields, sets resolutions to one and is ready on the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_channel_pwm_controller_top_assert.svh"
module multi_channel_pwm_controller_top #(
  parameter int CHANNEL_COUNT = mcpwm_pkg::CHANNELS_DEF,
  parameter int TIMER_COUNT   = mcpwm_pkg::TIMERS_DEF,
  parameter int MAX_RES_BITS  = mcpwm_pkg::RES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  command,
  input  wire  [3:0]  unit_index,
  input  wire  [3:0]  reg_select,
  input  wire  [31:0] write_data,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] read_data,
  output logic        irq,
  output logic [15:0] channel_levels
);
  localparam int CW = $clog2(CHANNEL_COUNT);
  localparam int TW = $clog2(TIMER_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_CALC, S_WAIT, S_DONE} state_t;

  state_t state;
  logic [1:0]  cmd;
  logic [3:0]  unit;
  logic [3:0]  sel;
  logic [31:0] data;
  logic [CW:0] scan;
  logic        pend;
  logic [CW-1:0] pch;

  logic [31:0] tsetup [TIMER_COUNT];
  logic [19:0] tcount [TIMER_COUNT];
  logic [4:0]  tres   [TIMER_COUNT];
  logic [31:0] csetup [CHANNEL_COUNT];
  logic [31:0] chp    [CHANNEL_COUNT];
  logic [31:0] cdset  [CHANNEL_COUNT];
  logic [31:0] csetup2[CHANNEL_COUNT];
  logic [31:0] cdnow  [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] clevel;
  logic [31:0] iraw;
  logic [31:0] iena;

  mcpwm_pkg::lvl_req_t req;
  logic lvl_out;
  logic [CW-1:0] rch;
  logic        ch_ok, tm_ok;
  logic [CW-1:0] uch;
  logic [TW-1:0] utm;

  function automatic logic [4:0] eff_res(logic [4:0] r);
    logic [4:0] x;
    x = r & mcpwm_pkg::RES_FIELD_MASK;
    if (x == 5'd0) x = 5'd1;
    if (x > 5'(MAX_RES_BITS)) x = 5'(MAX_RES_BITS);
    return x;
  endfunction

  function automatic logic [TW-1:0] timer_of(logic [31:0] conf, logic [3:0] c);
    logic [3:0] t;
    t = {2'b00, conf[mcpwm_pkg::TSEL_LO +: 2]} + (c >= 4'd8 ? 4'd4 : 4'd0);
    for (int k = 0; k < 3; k++) begin
      if (t >= 4'(TIMER_COUNT)) t = t - 4'(TIMER_COUNT);
    end
    return TW'(t);
  endfunction

  assign ch_ok = 32'(unit) < 32'(CHANNEL_COUNT);
  assign tm_ok = 32'(unit) < 32'(TIMER_COUNT);
  assign uch = unit[CW-1:0];
  assign utm = unit[TW-1:0];

  always_comb begin
    logic [TW-1:0] t;
    t = timer_of(csetup[rch], 4'(rch));
    req.cnt    = tcount[t];
    req.res    = eff_res(tres[t]);
    req.hpoint = chp[rch];
    req.duty   = cdnow[rch];
    req.en     = csetup[rch][mcpwm_pkg::EN_POS];
    req.idle   = csetup[rch][mcpwm_pkg::IDLE_POS];
  end

  mcpwm_level #(.MAX_RES_BITS(MAX_RES_BITS)) u_level (
    .clk   (clk),
    .req   (req),
    .level (lvl_out)
  );

  assign in_stall = (state != S_IDLE);
  assign rch = (state == S_SCAN) ? scan[CW-1:0] : pch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      read_data <= '0;
      irq <= 1'b0;
      channel_levels <= '0;
      pend <= 1'b0;
      pch <= '0;
      scan <= '0;
      iraw <= '0;
      iena <= '0;
      clevel <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        tsetup[i] <= '0;
        tcount[i] <= '0;
        tres[i] <= 5'd1;
      end
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        csetup[i] <= '0;
        chp[i] <= '0;
        cdset[i] <= '0;
        csetup2[i] <= '0;
        cdnow[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command;
            unit <= unit_index;
            sel <= reg_select;
            data <= write_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          read_data <= '0;
          pend <= 1'b0;
          pch <= uch;
          state <= S_DONE;
          if (cmd == mcpwm_pkg::CMD_READ) begin
            case (sel)
              mcpwm_pkg::SEL_TCONF:  read_data <= tm_ok ? tsetup[utm] : '0;
              mcpwm_pkg::SEL_TVALUE: read_data <= tm_ok ? 32'(tcount[utm]) : '0;
              mcpwm_pkg::SEL_CONF0:  read_data <= ch_ok ? csetup[uch] : '0;
              mcpwm_pkg::SEL_HPOINT: read_data <= ch_ok ? chp[uch] : '0;
              mcpwm_pkg::SEL_DUTY:   read_data <= ch_ok ? cdset[uch] : '0;
              mcpwm_pkg::SEL_CONF1:  read_data <= ch_ok ? csetup2[uch] : '0;
              mcpwm_pkg::SEL_DUTY_R: read_data <= ch_ok ? cdnow[uch] : '0;
              mcpwm_pkg::SEL_IRAW:   read_data <= iraw;
              mcpwm_pkg::SEL_IST:    read_data <= iraw & iena;
              mcpwm_pkg::SEL_IENA:   read_data <= iena;
              default:               read_data <= '0;
            endcase
          end else if (cmd == mcpwm_pkg::CMD_WRITE) begin
            case (sel)
              mcpwm_pkg::SEL_TCONF: begin
                if (tm_ok) begin
                  tsetup[utm] <= data;
                  if (data[4:0] != 5'd0) tres[utm] <= data[4:0];
                  tcount[utm] <= '0;
                end
              end
              mcpwm_pkg::SEL_CONF0: begin
                if (ch_ok) begin
                  csetup[uch] <= data;
                  pend <= 1'b1;
                  state <= S_CALC;
                end
              end
              mcpwm_pkg::SEL_HPOINT: if (ch_ok) chp[uch] <= data;
              mcpwm_pkg::SEL_DUTY: begin
                if (ch_ok) begin
                  cdset[uch] <= data;
                  cdnow[uch] <= data;
                  iraw[uch] <= 1'b1;
                  state <= S_CALC;
                end
              end
              mcpwm_pkg::SEL_CONF1: begin
                if (ch_ok) begin
                  csetup2[uch] <= data;
                  if (data[mcpwm_pkg::START_POS]) begin
                    cdnow[uch] <= cdset[uch];
                    iraw[uch] <= 1'b1;
                    state <= S_CALC;
                  end
                end
              end
              mcpwm_pkg::SEL_DUTY_R: begin
                if (ch_ok) begin
                  cdnow[uch] <= data;
                  state <= S_CALC;
                end
              end
              mcpwm_pkg::SEL_IRAW: iraw <= iraw | data;
              mcpwm_pkg::SEL_IENA: iena <= data;
              mcpwm_pkg::SEL_ICLR: iraw <= iraw & ~data;
              default: ;
            endcase
          end else if (cmd == mcpwm_pkg::CMD_TICK && tm_ok) begin
            logic [4:0]  r;
            logic [19:0] nc;
            r = eff_res(tres[utm]);
            nc = (tcount[utm] + 20'd1) & 20'((21'(1) << r) - 21'(1));
            tcount[utm] <= nc;
            if (nc == '0) iraw[mcpwm_pkg::IRQ_TMR_BASE + 32'(utm)] <= 1'b1;
            scan <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan != '0) begin
            if (csetup[pch][mcpwm_pkg::EN_POS] && timer_of(csetup[pch], 4'(pch)) == utm)
              clevel[pch] <= lvl_out;
          end
          pch <= scan[CW-1:0];
          if (32'(scan) == CHANNEL_COUNT) begin
            state <= S_WAIT;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_CALC: begin
          // level unit sees the updated channel registers this cycle
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (pend || cmd != mcpwm_pkg::CMD_TICK) begin
            clevel[pch] <= lvl_out;
          end else if (csetup[pch][mcpwm_pkg::EN_POS]
                       && timer_of(csetup[pch], 4'(pch)) == utm) begin
            clevel[pch] <= lvl_out;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            irq <= |(iraw & iena);
            channel_levels <= 16'(clevel);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PWM_ASSERT_IMP(a_stall_busy, clk, rst, out_valid, in_stall)
  `PWM_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(read_data))
  `PWM_ASSERT_NXT(a_take, clk, rst, in_valid && !in_stall, in_stall)
endmodule
`default_nettype wire
